// File: rtl/core/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// shared constants, operation codes and the command broadcast to the cell row
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 7;
    localparam int LEN_W      = 7;
    localparam int CAP_W      = 7;
    localparam int CAP_RESET  = 64;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int GRP_W      = 8;
    localparam int NGRP       = (DEPTH + GRP_W - 1) / GRP_W;

    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_RETRIEVE = 2'd2;

    // command seen by every cell in the cycle of an input transfer
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              rd;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// one list entry: loads, shifts from a neighbor or holds, and offers its word
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell (
    input  wire logic                          i_clk,
    input  wire pal_pkg::t_cmd                 i_cmd,
    input  wire logic [pal_pkg::CNT_W-1:0]     i_cell_pos,
    input  wire logic [pal_pkg::DATA_W-1:0]    i_left,
    input  wire logic [pal_pkg::DATA_W-1:0]    i_right,
    output logic      [pal_pkg::DATA_W-1:0]    o_data,
    output logic      [pal_pkg::DATA_W-1:0]    o_hit_data
);

    logic [pal_pkg::DATA_W-1:0] r_data;
    logic [pal_pkg::CMP_W-1:0]  me;
    logic                       hit;
    logic                       after;

    assign me    = pal_pkg::CMP_W'(i_cell_pos);
    assign hit   = (i_cmd.pos == me);
    assign after = (i_cmd.pos < me);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && hit) begin
            r_data <= i_cmd.value;
        end else if (i_cmd.ins && after) begin
            r_data <= i_left;
        end else if (i_cmd.rem && (hit || after)) begin
            r_data <= i_right;
        end
    end

    assign o_data     = r_data;
    assign o_hit_data = (i_cmd.rd && hit) ? r_data : '0;

endmodule

`default_nettype wire

// File: rtl/core/positional_array_list.sv
// pipeline: a transfer is registered in the group stage, then the output stage
// throughput: one item per cycle unless an output stall holds input; cells shift
// in parallel and a two-level registered or-tree carries a retrieved word out
// reset: length clears to zero, capacity returns to 64, entries stay undefined
// and need no clearing pass, so items are taken from the first cycle after reset
// ----------------------------------------------------------------------------
// positional_array_list
// ordered list of signed words with insert, remove and retrieve by position
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel (capacity)
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pal_pkg::CAP_W-1:0]     i_cfg_data,
    // item channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [pal_pkg::POS_W-1:0]     i_position,
    input  wire logic signed [pal_pkg::DATA_W-1:0] i_value_in,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_success,
    output logic signed [pal_pkg::DATA_W-1:0]  o_value_out,
    output logic      [pal_pkg::LEN_W-1:0]     o_length,
    output logic                               o_empty_res
);

    // control state
    logic [pal_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pal_pkg::CAP_W-1:0]  r_capacity;

    // first stage: or of each group of cells
    logic                       r_a_valid;
    logic                       r_a_ok;
    logic [pal_pkg::CNT_W-1:0]  r_a_count;
    logic [pal_pkg::DATA_W-1:0] r_a_grp [pal_pkg::NGRP];
    logic [pal_pkg::DATA_W-1:0] n_a_grp [pal_pkg::NGRP];

    // output stage
    logic                       r_out_valid;
    logic                       r_out_ok;
    logic [pal_pkg::DATA_W-1:0] r_out_value, n_out_value;
    logic [pal_pkg::CNT_W-1:0]  r_out_count;

    logic                       in_xfer;
    logic                       adv_a;
    logic [pal_pkg::CMP_W-1:0]  pos_ext;
    logic [pal_pkg::CMP_W-1:0]  cnt_ext;
    logic [pal_pkg::CMP_W-1:0]  cap_ext;
    logic [pal_pkg::CMP_W-1:0]  lim;
    logic                       pos_in_list;
    logic                       ins_ok;
    logic                       rem_ok;
    logic                       rd_ok;
    pal_pkg::t_cmd              cmd;

    logic [pal_pkg::DATA_W-1:0] cell_data [pal_pkg::DEPTH];
    logic [pal_pkg::DATA_W-1:0] hit_pad   [pal_pkg::NGRP * pal_pkg::GRP_W];

    // handshakes: the output register frees the first stage, which frees input
    assign o_cfg_ready = 1'b1;
    assign adv_a       = r_a_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_a_valid && !adv_a;
    assign in_xfer     = i_in_valid && !o_in_stall;

    // range checks against the length before this item
    assign pos_ext     = pal_pkg::CMP_W'(i_position);
    assign cnt_ext     = pal_pkg::CMP_W'(r_count);
    assign cap_ext     = pal_pkg::CMP_W'(r_capacity);
    assign lim         = (cap_ext < pal_pkg::CMP_W'(pal_pkg::DEPTH)) ? cap_ext
                                                                     : pal_pkg::CMP_W'(pal_pkg::DEPTH);
    assign pos_in_list = (pos_ext != '0) && (pos_ext <= cnt_ext);

    always_comb begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        rd_ok  = 1'b0;
        unique case (i_mode)
            pal_pkg::MODE_INSERT: begin
                ins_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + pal_pkg::CMP_W'(1))
                         && (cnt_ext < lim);
            end
            pal_pkg::MODE_REMOVE: begin
                rem_ok = pos_in_list;
            end
            pal_pkg::MODE_RETRIEVE: begin
                rd_ok = pos_in_list;
            end
            default: begin
                ins_ok = 1'b0;
            end
        endcase
    end

    // command broadcast to the cell row, live only on a transfer
    always_comb begin
        cmd.ins   = in_xfer && ins_ok;
        cmd.rem   = in_xfer && rem_ok;
        cmd.rd    = in_xfer && rd_ok;
        cmd.pos   = pos_ext;
        cmd.value = i_value_in;
    end

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + pal_pkg::CNT_W'(1);
        end else if (cmd.rem) begin
            n_count = r_count - pal_pkg::CNT_W'(1);
        end
    end

    // row of cells: insert pulls from the left neighbor, remove from the right
    genvar gi;
    generate
        for (gi = 0; gi < pal_pkg::DEPTH; gi++) begin : g_cell
            logic [pal_pkg::DATA_W-1:0] left_w;
            logic [pal_pkg::DATA_W-1:0] right_w;
            if (gi == 0) begin : g_first
                assign left_w = '0;
            end else begin : g_mid_l
                assign left_w = cell_data[gi-1];
            end
            if (gi == pal_pkg::DEPTH - 1) begin : g_last
                assign right_w = '0;
            end else begin : g_mid_r
                assign right_w = cell_data[gi+1];
            end
            pal_cell u_cell (
                .i_clk      (i_clk),
                .i_cmd      (cmd),
                .i_cell_pos (pal_pkg::CNT_W'(gi + 1)),
                .i_left     (left_w),
                .i_right    (right_w),
                .o_data     (cell_data[gi]),
                .o_hit_data (hit_pad[gi])
            );
        end
        for (gi = pal_pkg::DEPTH; gi < pal_pkg::NGRP * pal_pkg::GRP_W; gi++) begin : g_pad
            assign hit_pad[gi] = '0;
        end
    endgenerate

    // at most one cell offers a nonzero word, so an or-tree selects it
    always_comb begin
        for (int g = 0; g < pal_pkg::NGRP; g++) begin
            n_a_grp[g] = '0;
            for (int k = 0; k < pal_pkg::GRP_W; k++) begin
                n_a_grp[g] = n_a_grp[g] | hit_pad[g * pal_pkg::GRP_W + k];
            end
        end
    end

    always_comb begin
        n_out_value = '0;
        for (int g = 0; g < pal_pkg::NGRP; g++) begin
            n_out_value = n_out_value | r_a_grp[g];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_capacity  <= pal_pkg::CAP_W'(pal_pkg::CAP_RESET);
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (in_xfer) begin
                r_a_valid <= 1'b1;
            end else if (adv_a) begin
                r_a_valid <= 1'b0;
            end
            if (adv_a) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_ok    <= ins_ok || rem_ok || rd_ok;
            r_a_count <= n_count;
            r_a_grp   <= n_a_grp;
        end
        if (adv_a) begin
            r_out_ok    <= r_a_ok;
            r_out_value <= n_out_value;
            r_out_count <= r_a_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_success   = r_out_ok;
    assign o_value_out = r_out_value;
    assign o_length    = pal_pkg::LEN_W'(r_out_count);
    assign o_empty_res = (r_out_count == '0);

endmodule

`default_nettype wire

// File: rtl/core/pal_checker.sv
// ----------------------------------------------------------------------------
// pal_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pal_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic                          o_success,
    input  wire logic [pal_pkg::DATA_W-1:0]    o_value_out,
    input  wire logic [pal_pkg::LEN_W-1:0]     o_length,
    input  wire logic                          o_empty_res
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_empty_res == (o_length == '0)))
        else $error("empty flag disagrees with length");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_success |-> (o_value_out == '0))
        else $error("rejected item returned a value");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_length <= pal_pkg::LEN_W'(pal_pkg::DEPTH)))
        else $error("length beyond store depth");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_success   (o_success),
    .o_value_out (o_value_out),
    .o_length    (o_length),
    .o_empty_res (o_empty_res)
);

`default_nettype wire
